// File: src/rv64im_subset_core_assert.svh
// rv64im_subset_core_assert.svh: assertion macros for the rv64im_subset_core checker.
// Holds no logic and depends on nothing else.
`ifndef RV64IM_SUBSET_CORE_ASSERT_SVH
`define RV64IM_SUBSET_CORE_ASSERT_SVH
// A property checked at every rising clock edge, off while reset is applied.
`define RVC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rv64im_subset_core: assertion failed");
// A property whose consequent is checked in the cycle after the antecedent holds.
`define RVC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rv64im_subset_core: assertion failed");
`endif

// File: src/rvc_pkg.sv
// rvc_pkg.sv: types, constants and helpers shared by the rv64im_subset_core files.
// Depends on nothing.
package rvc_pkg;

  localparam int MemBytes = 65536;
  localparam int MemAw    = $clog2(MemBytes);
  localparam int NumRegs  = 32;

  localparam logic [1:0] ReqLoadByte = 2'd0;
  localparam logic [1:0] ReqStart    = 2'd1;
  localparam logic [1:0] ReqExec     = 2'd2;

  localparam logic [1:0] CfgStartPc = 2'd0;
  localparam logic [1:0] CfgEndPc   = 2'd1;
  localparam logic [1:0] CfgGpInit  = 2'd2;
  localparam logic [1:0] CfgSpInit  = 2'd3;

  localparam logic [4:0]  RegZero = 5'd0;
  localparam logic [4:0]  RegSp   = 5'd2;
  localparam logic [4:0]  RegGp   = 5'd3;
  localparam logic [63:0] SpReset = 64'd32768;

  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpImmW   = 7'h1B;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpRegW   = 7'h3B;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpSystem = 7'h73;
  localparam logic [31:0] InstEcall = 32'h0000_0073;

  typedef enum logic [2:0] {
    MdMul, MdMulh, MdMulw, MdDiv, MdRem, MdDivw
  } md_op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] load_addr;
    logic [7:0]  load_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        halted;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;
    logic        store_done;
    logic [31:0] access_addr;
    logic        unknown_inst;
  } rsp_t;

  typedef struct packed {
    logic        start;
    md_op_e      op;
    logic [63:0] a;
    logic [63:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } md_rsp_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// File: src/rv64im_subset_core.sv
// rv64im_subset_core: small RV64IM subset core built around a byte data memory
// and a register file memory, both synchronous RAMs with a registered read port.
//
// Channels: a request channel (in_valid_i/in_ready_o/in_data_i) carries one
// request: write a memory byte, start the core, or execute one instruction.
// Every request gives exactly one result on out_valid_o/out_ready_i/out_data_o.
// Configuration (start_pc, end_pc, gp_init, sp_init) is written through cfg_we_i/
// cfg_idx_i/cfg_data_i with no handshake; the user must write it only while the
// core is idle, which the core itself does not enforce.
// A byte write, an unused request type or an execute at end_pc goes straight to
// the output register; a start writes sp, then gp; any other execute reads four
// instruction bytes from the byte memory, then its registers, executes and writes
// back, with N byte reads for an N-byte load, N byte writes for an N-byte store
// and multiply and divide iterating one bit per cycle. One request is in work at
// a time; the byte memory port sets the pace. Reset: the core sweeps the whole
// byte memory to zero, one byte a cycle, and accepts no request until that is done.
// Stall: a finished result waits in the output register; the next request is
// accepted meanwhile, and its result waits until the register is free.
module rv64im_subset_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rvc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rvc_pkg::rsp_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i
);
  import rvc_pkg::*;

  typedef enum logic [3:0] {
    SClear, SIdle, SStart2, SRdA, SRdD, SDec, SRs2, SOpb, SExec,
    SLdx, SStore, SMd, SWb, SFin
  } state_e;

  typedef enum logic [1:0] {KAlu, KLoad, KStore, KMd} kind_e;

  // Register-register function keys, {funct7, funct3}.
  localparam logic [9:0] RAdd = 10'h000, RMul = 10'h008, RSub = 10'h100;
  localparam logic [9:0] RSll = 10'h001, RMulh = 10'h009, RSlt = 10'h002;
  localparam logic [9:0] RXor = 10'h004, RDiv = 10'h00C, RSrl = 10'h005;
  localparam logic [9:0] RSra = 10'h105, ROr = 10'h006, RRem = 10'h00E;
  localparam logic [9:0] RAnd = 10'h007;
  localparam logic [2:0] F3Add = 3'd0, F3Sll = 3'd1, F3Slt = 3'd2, F3Xor = 3'd4;
  localparam logic [2:0] F3Srl = 3'd5, F3Or = 3'd6, F3And = 3'd7;
  localparam logic [2:0] F3Beq = 3'd0, F3Bne = 3'd1, F3Blt = 3'd4, F3Bge = 3'd5;
  localparam logic [6:0] F7Base = 7'h00, F7Muldiv = 7'h01;
  localparam logic [5:0] F6Logic = 6'h00, F6Arith = 6'h10;
  localparam logic [MemAw-1:0] MemLast = MemAw'(MemBytes - 1);

  state_e state_q, state_d;

  // Control state.
  logic [MemAw-1:0]   clr_addr_q;
  logic               out_valid_q;
  logic [NumRegs-1:0] rf_valid_q;
  logic [31:0]        pc_q, start_pc_q, end_pc_q;
  logic [63:0]        gp_init_q, sp_init_q;

  // Per-request working registers.
  logic [MemAw-1:0] addr_q;
  logic [2:0]       cnt_q, last_q;
  logic             is_fetch_q;
  logic [63:0]      buf_q, a_q, b_q, v_q;
  logic [31:0]      inst_q, next_q;
  logic             wr_q, known_q;
  rsp_t             res_q, out_q;

  logic accept, out_free;
  logic [MemAw-1:0] addr_inc;

  logic             dm_we;
  logic [MemAw-1:0] dm_waddr, dm_raddr;
  logic [7:0]       dm_wdata, dm_rdata;
  logic             rf_we;
  logic [4:0]       rf_waddr, rf_raddr;
  logic [63:0]      rf_wdata, rf_rdata;

  md_req_t md_req;
  md_rsp_t md_rsp;

  // Instruction fields.
  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [5:0]  f6;
  logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j;

  // Execute results.
  logic [63:0] ex_v, ex_sum;
  logic [31:0] ex_next, ex_ea;
  logic        ex_wr, ex_known, ex_cond;
  kind_e       ex_kind;
  md_op_e      ex_md;
  logic [63:0] ld_val;

  assign accept   = in_valid_i && (state_q == SIdle);
  assign out_free = !out_valid_q || out_ready_i;
  assign addr_inc = (addr_q == MemLast) ? '0 : addr_q + MemAw'(1);

  assign opc = inst_q[6:0];
  assign rd  = inst_q[11:7];
  assign f3  = inst_q[14:12];
  assign rs1 = inst_q[19:15];
  assign rs2 = inst_q[24:20];
  assign f7  = inst_q[31:25];
  assign f6  = inst_q[31:26];

  assign imm_i = {{52{inst_q[31]}}, inst_q[31:20]};
  assign imm_s = {{52{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
  assign imm_b = {{51{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25], inst_q[11:8], 1'b0};
  assign imm_u = {{32{inst_q[31]}}, inst_q[31:12], 12'b0};
  assign imm_j = {{43{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21],
                  1'b0};

  // Decode and combinational ALU. Loads, stores and multiply/divide only set up
  // their address or operation here and finish in later states.
  always_comb begin
    ex_v     = '0;
    ex_wr    = 1'b0;
    ex_known = 1'b1;
    ex_next  = pc_q + 32'd4;
    ex_ea    = '0;
    ex_kind  = KAlu;
    ex_md    = MdMul;
    ex_cond  = 1'b0;
    ex_sum   = a_q + imm_i;
    case (opc)
      OpReg: begin
        ex_wr = 1'b1;
        case ({f7, f3})
          RAdd:  ex_v = a_q + b_q;
          RSub:  ex_v = a_q - b_q;
          RSll:  ex_v = a_q << b_q[5:0];
          RSlt:  ex_v = {63'd0, $signed(a_q) < $signed(b_q)};
          RXor:  ex_v = a_q ^ b_q;
          RSrl:  ex_v = a_q >> b_q[5:0];
          RSra:  ex_v = $unsigned($signed(a_q) >>> b_q[5:0]);
          ROr:   ex_v = a_q | b_q;
          RAnd:  ex_v = a_q & b_q;
          RMul: begin
            ex_kind = KMd;
            ex_md   = MdMul;
          end
          RMulh: begin
            ex_kind = KMd;
            ex_md   = MdMulh;
          end
          RDiv: begin
            ex_kind = KMd;
            ex_md   = MdDiv;
          end
          RRem: begin
            ex_kind = KMd;
            ex_md   = MdRem;
          end
          default: begin
            ex_wr    = 1'b0;
            ex_known = 1'b0;
          end
        endcase
      end
      OpImm: begin
        ex_wr = 1'b1;
        case (f3)
          F3Add: ex_v = ex_sum;
          F3Sll: begin
            if (f6 == F6Logic) ex_v = a_q << imm_i[5:0];
            else ex_known = 1'b0;
          end
          F3Slt: ex_v = {63'd0, $signed(a_q) < $signed(imm_i)};
          F3Xor: ex_v = a_q ^ imm_i;
          F3Srl: begin
            if (f6 == F6Logic) ex_v = a_q >> imm_i[5:0];
            else if (f6 == F6Arith) ex_v = $unsigned($signed(a_q) >>> imm_i[5:0]);
            else ex_known = 1'b0;
          end
          F3Or:  ex_v = a_q | imm_i;
          F3And: ex_v = a_q & imm_i;
          default: ex_known = 1'b0;
        endcase
        if (!ex_known) ex_wr = 1'b0;
      end
      OpImmW: begin
        if (f3 == F3Add) begin
          ex_wr = 1'b1;
          ex_v  = sext32(ex_sum[31:0]);
        end else begin
          ex_known = 1'b0;
        end
      end
      OpLoad: begin
        if (!f3[2]) begin
          ex_wr   = 1'b1;
          ex_kind = KLoad;
          ex_ea   = ex_sum[31:0];
        end else begin
          ex_known = 1'b0;
        end
      end
      OpStore: begin
        if (!f3[2]) begin
          ex_kind = KStore;
          ex_ea   = a_q[31:0] + imm_s[31:0];
        end else begin
          ex_known = 1'b0;
        end
      end
      OpBranch: begin
        case (f3)
          F3Beq: ex_cond = (a_q == b_q);
          F3Bne: ex_cond = (a_q != b_q);
          F3Blt: ex_cond = $signed(a_q) < $signed(b_q);
          F3Bge: ex_cond = !($signed(a_q) < $signed(b_q));
          default: ex_known = 1'b0;
        endcase
        if (ex_cond) ex_next = pc_q + imm_b[31:0];
      end
      OpAuipc: begin
        ex_wr = 1'b1;
        ex_v  = {32'd0, pc_q} + imm_u;
      end
      OpLui: begin
        ex_wr = 1'b1;
        ex_v  = imm_u;
      end
      OpJal: begin
        ex_wr   = 1'b1;
        ex_v    = {32'd0, pc_q + 32'd4};
        ex_next = pc_q + imm_j[31:0];
      end
      OpJalr: begin
        if (f3 == F3Add) begin
          ex_wr   = 1'b1;
          ex_v    = {32'd0, pc_q + 32'd4};
          ex_next = {ex_sum[31:1], 1'b0};
        end else begin
          ex_known = 1'b0;
        end
      end
      OpRegW: begin
        ex_wr = 1'b1;
        if (f7 == F7Base && f3 == F3Add) begin
          ex_v = sext32(a_q[31:0] + b_q[31:0]);
        end else if (f7 == F7Muldiv && f3 == F3Add) begin
          ex_kind = KMd;
          ex_md   = MdMulw;
        end else if (f7 == F7Muldiv && f3 == F3Xor) begin
          ex_kind = KMd;
          ex_md   = MdDivw;
        end else begin
          ex_wr    = 1'b0;
          ex_known = 1'b0;
        end
      end
      OpSystem: begin
        if (inst_q != InstEcall) ex_known = 1'b0;
      end
      default: ex_known = 1'b0;
    endcase
  end

  always_comb begin
    case (f3[1:0])
      2'd0:    ld_val = {{56{buf_q[7]}}, buf_q[7:0]};
      2'd1:    ld_val = {{48{buf_q[15]}}, buf_q[15:0]};
      2'd2:    ld_val = {{32{buf_q[31]}}, buf_q[31:0]};
      default: ld_val = buf_q;
    endcase
  end

  // Byte memory port selection.
  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = addr_q;
    dm_wdata = b_q[{cnt_q, 3'b000} +: 8];
    dm_raddr = addr_q;
    case (state_q)
      SClear: begin
        dm_we    = 1'b1;
        dm_waddr = clr_addr_q;
        dm_wdata = '0;
      end
      SIdle: begin
        if (accept && in_data_i.req_type == ReqLoadByte) begin
          dm_we    = 1'b1;
          dm_waddr = MemAw'(in_data_i.load_addr % MemBytes);
          dm_wdata = in_data_i.load_byte;
        end
      end
      SStore: dm_we = 1'b1;
      default: ;
    endcase
  end

  // Register file port selection. Entries whose valid bit is clear read as zero.
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rd;
    rf_wdata = v_q;
    rf_raddr = rs2;
    case (state_q)
      SIdle: begin
        if (accept && in_data_i.req_type == ReqStart) begin
          rf_we    = 1'b1;
          rf_waddr = RegSp;
          rf_wdata = sp_init_q;
        end
      end
      SStart2: begin
        rf_we    = 1'b1;
        rf_waddr = RegGp;
        rf_wdata = gp_init_q;
      end
      SDec:    rf_raddr = buf_q[19:15];
      SWb:     rf_we = wr_q && (rd != RegZero);
      default: ;
    endcase
  end

  assign md_req.start = (state_q == SExec) && (ex_kind == KMd);
  assign md_req.op    = ex_md;
  assign md_req.a     = a_q;
  assign md_req.b     = b_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SClear: if (clr_addr_q == MemLast) state_d = SIdle;
      SIdle: begin
        if (accept) begin
          case (in_data_i.req_type)
            ReqStart: state_d = SStart2;
            ReqExec:  state_d = (pc_q == end_pc_q) ? SFin : SRdA;
            default:  state_d = SFin;
          endcase
        end
      end
      SStart2: state_d = SFin;
      SRdA:    state_d = SRdD;
      SRdD: begin
        if (cnt_q != last_q) state_d = SRdA;
        else if (is_fetch_q) state_d = SDec;
        else state_d = SLdx;
      end
      SDec: state_d = SRs2;
      SRs2: state_d = SOpb;
      SOpb: state_d = SExec;
      SExec: begin
        case (ex_kind)
          KLoad:   state_d = SRdA;
          KStore:  state_d = SStore;
          KMd:     state_d = SMd;
          default: state_d = SWb;
        endcase
      end
      SLdx:   state_d = SWb;
      SStore: if (cnt_q == last_q) state_d = SWb;
      SMd:    if (md_rsp.done) state_d = SWb;
      SWb:    state_d = SFin;
      SFin:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      rf_valid_q  <= '0;
      pc_q        <= '0;
      start_pc_q  <= '0;
      end_pc_q    <= '0;
      gp_init_q   <= '0;
      sp_init_q   <= SpReset;
    end else begin
      state_q <= state_d;
      if (state_q == SClear) clr_addr_q <= clr_addr_q + MemAw'(1);
      if (state_q == SFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept && in_data_i.req_type == ReqStart) begin
        rf_valid_q        <= '0;
        rf_valid_q[RegSp] <= 1'b1;
        pc_q              <= start_pc_q;
      end
      if (state_q == SStart2) rf_valid_q[RegGp] <= 1'b1;
      if (state_q == SWb) begin
        pc_q <= next_q;
        if (wr_q && rd != RegZero) rf_valid_q[rd] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartPc: start_pc_q <= cfg_data_i[31:0];
          CfgEndPc:   end_pc_q   <= cfg_data_i[31:0];
          CfgGpInit:  gp_init_q  <= cfg_data_i;
          CfgSpInit:  sp_init_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (accept) begin
          res_q      <= '0;
          addr_q     <= MemAw'(pc_q % MemBytes);
          cnt_q      <= '0;
          last_q     <= 3'd3;
          is_fetch_q <= 1'b1;
        end
      end
      SRdD: begin
        buf_q[{cnt_q, 3'b000} +: 8] <= dm_rdata;
        cnt_q  <= cnt_q + 3'd1;
        addr_q <= addr_inc;
      end
      SDec: inst_q <= buf_q[31:0];
      SRs2: a_q <= rf_valid_q[rs1] ? rf_rdata : 64'd0;
      SOpb: b_q <= rf_valid_q[rs2] ? rf_rdata : 64'd0;
      SExec: begin
        v_q     <= ex_v;
        wr_q    <= ex_wr;
        known_q <= ex_known;
        next_q  <= ex_next;
        if (ex_kind == KLoad || ex_kind == KStore) begin
          addr_q            <= MemAw'(ex_ea % MemBytes);
          cnt_q             <= '0;
          last_q            <= (3'd1 << f3[1:0]) - 3'd1;
          is_fetch_q        <= 1'b0;
          res_q.access_addr <= ex_ea;
          res_q.store_done  <= (ex_kind == KStore);
        end
      end
      SLdx: v_q <= ld_val;
      SStore: begin
        cnt_q  <= cnt_q + 3'd1;
        addr_q <= addr_inc;
      end
      SMd: if (md_rsp.done) v_q <= md_rsp.result;
      SWb: begin
        res_q.unknown_inst <= !known_q;
        if (wr_q && rd != RegZero) begin
          res_q.reg_written <= 1'b1;
          res_q.dest_index  <= rd;
          res_q.dest_value  <= v_q;
        end
      end
      SFin: begin
        if (out_free) begin
          out_q          <= res_q;
          out_q.pc_after <= pc_q;
          out_q.halted   <= (pc_q == end_pc_q);
        end
      end
      default: ;
    endcase
  end

  rvc_ram #(
    .Width(8),
    .Depth(MemBytes)
  ) u_dmem (
    .clk_i  (clk_i),
    .we_i   (dm_we),
    .waddr_i(dm_waddr),
    .wdata_i(dm_wdata),
    .raddr_i(dm_raddr),
    .rdata_o(dm_rdata)
  );

  rvc_ram #(
    .Width(64),
    .Depth(NumRegs)
  ) u_regfile (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .raddr_i(rf_raddr),
    .rdata_o(rf_rdata)
  );

  rvc_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (md_req),
    .rsp_o (md_rsp)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/rvc_ram.sv
// rvc_ram.sv: generic single-write, single-read RAM with a registered read port.
// Stand-alone; width and depth come from its parameters.
module rvc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rvc_muldiv.sv
// rvc_muldiv.sv: iterative 64-bit multiply and divide unit, one bit per cycle.
// Depends on rvc_pkg for the request and response types.
module rvc_muldiv (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rvc_pkg::md_req_t req_i,
  output rvc_pkg::md_rsp_t rsp_o
);
  import rvc_pkg::*;

  typedef enum logic [1:0] {MdIdle, MdRun, MdFix} md_state_e;

  md_state_e   state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  md_op_e      op_q;
  logic [63:0] opa_q, opb_q, mag_q, lo_q, res_q;
  logic [64:0] hi_q;
  logic        an_q, bn_q;

  logic        is_div;
  logic [63:0] da, db;
  logic [64:0] msum, rshift, rdiff;
  logic [63:0] q_signed, r_signed, fix_res;

  assign is_div = (req_i.op == MdDiv) || (req_i.op == MdRem) || (req_i.op == MdDivw);
  assign da = (req_i.op == MdDivw) ? sext32(req_i.a[31:0]) : req_i.a;
  assign db = (req_i.op == MdDivw) ? sext32(req_i.b[31:0]) : req_i.b;

  // Multiply step adds the multiplicand when the low bit is set; divide step
  // tries to subtract the divisor magnitude from the shifted partial remainder.
  assign msum   = {1'b0, hi_q[63:0]} + (lo_q[0] ? {1'b0, opa_q} : 65'd0);
  assign rshift = {hi_q[63:0], lo_q[63]};
  assign rdiff  = rshift - {1'b0, mag_q};

  assign q_signed = (an_q != bn_q) ? (64'd0 - lo_q) : lo_q;
  assign r_signed = an_q ? (64'd0 - hi_q[63:0]) : hi_q[63:0];

  always_comb begin
    case (op_q)
      MdMul:   fix_res = lo_q;
      MdMulw:  fix_res = sext32(lo_q[31:0]);
      MdMulh:  fix_res = hi_q[63:0] - (an_q ? opb_q : 64'd0) - (bn_q ? opa_q : 64'd0);
      MdDiv:   fix_res = (opb_q == 64'd0) ? '1 : q_signed;
      MdDivw:  fix_res = (opb_q == 64'd0) ? '1 : sext32(q_signed[31:0]);
      MdRem:   fix_res = (opb_q == 64'd0) ? opa_q : r_signed;
      default: fix_res = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      MdIdle: begin
        if (req_i.start) begin
          state_d = MdRun;
          cnt_d   = '0;
        end
      end
      MdRun: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = MdFix;
        end
      end
      MdFix: begin
        done_d  = 1'b1;
        state_d = MdIdle;
      end
      default: state_d = MdIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MdIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MdIdle: begin
        if (req_i.start) begin
          op_q  <= req_i.op;
          opa_q <= da;
          opb_q <= db;
          an_q  <= da[63];
          bn_q  <= db[63];
          mag_q <= db[63] ? (64'd0 - db) : db;
          hi_q  <= '0;
          lo_q  <= is_div ? (da[63] ? (64'd0 - da) : da) : req_i.b;
        end
      end
      MdRun: begin
        if ((op_q == MdDiv) || (op_q == MdRem) || (op_q == MdDivw)) begin
          if (!rdiff[64]) begin
            hi_q <= rdiff;
          end else begin
            hi_q <= rshift;
          end
          lo_q <= {lo_q[62:0], ~rdiff[64]};
        end else begin
          hi_q <= {1'b0, msum[64:1]};
          lo_q <= {msum[0], lo_q[63:1]};
        end
      end
      MdFix: res_q <= fix_res;
      default: ;
    endcase
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

// File: src/rvc_checker.sv
// rvc_checker.sv: port-level assertions for rv64im_subset_core, bound to the top level.
// Depends on rvc_pkg and the macros in rv64im_subset_core_assert.svh.
`include "rv64im_subset_core_assert.svh"

module rvc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rvc_pkg::rsp_t out_data_o
);
  import rvc_pkg::*;

  // A result that is not taken stays, unchanged.
  `RVC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // Without a register write the destination fields are zero.
  `RVC_ASSERT(a_no_write_zero, clk_i, rst_ni, out_valid_o && !out_data_o.reg_written |-> out_data_o.dest_index == 5'd0 && out_data_o.dest_value == 64'd0)
  // A reported write never names x0.
  `RVC_ASSERT(a_write_nonzero, clk_i, rst_ni, out_valid_o && out_data_o.reg_written |-> out_data_o.dest_index != 5'd0)
  // An unrecognized instruction writes no register and makes no memory access.
  `RVC_ASSERT(a_unknown_quiet, clk_i, rst_ni, out_valid_o && out_data_o.unknown_inst |-> !out_data_o.reg_written && !out_data_o.store_done && out_data_o.access_addr == 32'd0)
  // A store never writes a register.
  `RVC_ASSERT(a_store_no_write, clk_i, rst_ni, out_valid_o && out_data_o.store_done |-> !out_data_o.reg_written)

endmodule

bind rv64im_subset_core rvc_checker u_rvc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
